// ===== rtl/core/dpp_pkg.sv =====
// ----------------------------------------------------------------------------
// dpp_pkg: shared types, constants and arithmetic helpers
// Q8.24 saturating helpers, beat structs and a divider step function for the
// distorted depth back-projection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package dpp_pkg;

	localparam int MAX_COLUMNS = 4096;
	localparam int MAX_ROWS    = 4096;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K12   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K34   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K56   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TANGENTIAL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_VALID   = 3'd6;

	typedef logic signed [31:0] q_t;

	localparam q_t Q_ONE = 32'sh0100_0000;
	localparam q_t Q_MAX = 32'sh7FFF_FFFF;
	localparam q_t Q_MIN = 32'sh8000_0000;
	localparam logic signed [32:0] S33_MAX = 33'sd2147483647;
	localparam logic signed [32:0] S33_MIN = -33'sd2147483648;
	localparam logic [31:0] Z_MISSING = 32'hFFFF_0000;

	// kr divider: restoring, DIV_BITS quotient bits per stage
	localparam int DIV_BITS  = 2;
	localparam int DIV_STEPS = 32 / DIV_BITS;

	// depth scaling: /256000 = >>11 then /125, /1000 = >>3 then /125
	// the /125 splits the shifted sum into two 18-bit halves and divides each
	// by a reciprocal multiply; exact for operands below 2^25
	localparam logic [7:0]  DIV_C       = 8'd125;
	localparam logic [25:0] RCP_125     = 26'd34359739;
	localparam logic [47:0] RND_SCALE   = 48'd128000;
	localparam int          SCALE_SHIFT = 11;
	localparam logic [31:0] Z_RND       = 32'd500;
	localparam int          Z_SHIFT     = 3;
	localparam int          SC_SPLIT    = 18;
	localparam int          SC_LANES    = 3;

	localparam int NORM_LAT  = 7;
	localparam int POLY_LAT  = 6;
	localparam int DIV_LAT   = DIV_STEPS + 2;
	localparam int RAY_LAT   = 3;
	localparam int SCALE_LAT = 6;
	localparam int PIPE_LAT  = NORM_LAT + POLY_LAT + DIV_LAT + RAY_LAT + SCALE_LAT;

	typedef struct packed {
		logic [15:0] depth_mm;
		logic [11:0] pixel_column;
		logic [11:0] pixel_row;
	} pixel_t;

	typedef struct packed {
		q_t x_coord;
		q_t y_coord;
		q_t z_coord;
	} point_t;

	typedef struct packed {
		logic [15:0] depth;
		logic        en;
	} tag_t;

	typedef struct packed {
		q_t   x;
		q_t   y;
		q_t   two_xy;
		q_t   ax;
		q_t   ay;
		tag_t tag;
	} ctx_t;

	typedef struct packed {
		q_t k1;
		q_t k2;
		q_t k3;
		q_t k4;
		q_t k5;
		q_t k6;
	} lens_t;

	typedef struct packed {
		logic ovf;
		logic mdz;
		logic mnz;
		logic nneg;
		logic neg;
	} dflag_t;

	typedef struct packed {
		logic [31:0]         rem;
		logic [DIV_BITS-1:0] q;
	} dstep_t;

	function automatic q_t sat33(input logic signed [32:0] v);
		q_t r;
		if (v > S33_MAX) begin
			r = Q_MAX;
		end else if (v < S33_MIN) begin
			r = Q_MIN;
		end else begin
			r = q_t'(v[31:0]);
		end
		return r;
	endfunction

	function automatic q_t q_add(input q_t a, input q_t b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		return sat33(s);
	endfunction

	function automatic q_t apply_sign(input logic [47:0] m, input logic neg);
		q_t r;
		if (neg) begin
			if (m > 48'h0000_8000_0000) r = Q_MIN;
			else r = q_t'(-m[31:0]);
		end else begin
			if (m > 48'h0000_7FFF_FFFF) r = Q_MAX;
			else r = q_t'(m[31:0]);
		end
		return r;
	endfunction

	// round a Q16.48 product to Q8.24, halves away from zero
	function automatic q_t mul_round(input logic signed [63:0] p);
		logic [63:0] mg;
		logic [63:0] rs;
		mg = p[63] ? $unsigned(-p) : $unsigned(p);
		rs = (mg + 64'd8388608) >> 24;
		return apply_sign(rs[47:0], p[63]);
	endfunction

	function automatic q_t norm_round(input logic [63:0] m, input logic neg);
		logic [63:0] s;
		s = (m >> 24) + {63'b0, m[23]};
		return apply_sign(s[47:0], neg);
	endfunction

	function automatic dstep_t div_step(input logic [31:0] rem,
		input logic [DIV_BITS-1:0] bits, input logic [31:0] md);
		dstep_t o;
		logic [32:0] r;
		o.rem = rem;
		o.q   = '0;
		for (int i = DIV_BITS - 1; i >= 0; i--) begin
			r = {o.rem, bits[i]};
			if (r >= {1'b0, md}) begin
				r      = r - {1'b0, md};
				o.q[i] = 1'b1;
			end
			o.rem = r[31:0];
		end
		return o;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dpp_norm.sv =====
// ----------------------------------------------------------------------------
// dpp_norm: pixel normalization and second-order terms
// Turns column/row into Q8.24 x,y and forms r2, 2xy, r2+2x2, r2+2y2.
// ----------------------------------------------------------------------------
`default_nettype none

module dpp_norm (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  dpp_pkg::pixel_t pix,
	input  logic [63:0]     inv_focal,
	input  logic [63:0]     principal,
	input  logic            coef_valid,
	output logic            out_valid,
	output dpp_pkg::q_t     r2,
	output dpp_pkg::ctx_t   ctx
);
	import dpp_pkg::*;

	logic [NORM_LAT:1] vld_s;
	tag_t tag_s [1:NORM_LAT];

	logic signed [32:0] dx, dy;
	logic [31:0] magx_s1, magy_s1;
	logic        negx_s1, negy_s1, negx_s2, negy_s2;
	logic [63:0] mx_s2, my_s2;
	q_t x_s3, y_s3, x_s4, y_s4, x_s5, y_s5, x_s6, y_s6;
	logic signed [63:0] px2_s4, py2_s4, pxy_s4;
	q_t x2_s5, y2_s5, xy_s5;
	q_t r2_s6, txy_s6, x2d_s6, y2d_s6;
	q_t x_s7, y_s7, r2_s7, txy_s7, ax_s7, ay_s7;

	assign dx = $signed({5'b0, pix.pixel_column, 16'b0}) - $signed({1'b0, principal[31:0]});
	assign dy = $signed({5'b0, pix.pixel_row, 16'b0}) - $signed({1'b0, principal[63:32]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[NORM_LAT-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		tag_s[1].depth <= pix.depth_mm;
		tag_s[1].en    <= coef_valid && (int'(pix.pixel_column) < MAX_COLUMNS)
			&& (int'(pix.pixel_row) < MAX_ROWS);
		for (int k = 2; k <= NORM_LAT; k++) begin
			tag_s[k] <= tag_s[k-1];
		end
		// s1: offsets from the principal point, sign and magnitude
		negx_s1 <= dx[32];
		negy_s1 <= dy[32];
		magx_s1 <= dx[32] ? 32'(-dx) : dx[31:0];
		magy_s1 <= dy[32] ? 32'(-dy) : dy[31:0];
		// s2: scale by inverse focal length
		negx_s2 <= negx_s1;
		negy_s2 <= negy_s1;
		mx_s2   <= 64'(magx_s1) * 64'(inv_focal[31:0]);
		my_s2   <= 64'(magy_s1) * 64'(inv_focal[63:32]);
		// s3
		x_s3 <= norm_round(mx_s2, negx_s2);
		y_s3 <= norm_round(my_s2, negy_s2);
		// s4
		x_s4   <= x_s3;
		y_s4   <= y_s3;
		px2_s4 <= x_s3 * x_s3;
		py2_s4 <= y_s3 * y_s3;
		pxy_s4 <= x_s3 * y_s3;
		// s5
		x_s5  <= x_s4;
		y_s5  <= y_s4;
		x2_s5 <= mul_round(px2_s4);
		y2_s5 <= mul_round(py2_s4);
		xy_s5 <= mul_round(pxy_s4);
		// s6
		x_s6   <= x_s5;
		y_s6   <= y_s5;
		r2_s6  <= q_add(x2_s5, y2_s5);
		txy_s6 <= q_add(xy_s5, xy_s5);
		x2d_s6 <= q_add(x2_s5, x2_s5);
		y2d_s6 <= q_add(y2_s5, y2_s5);
		// s7
		x_s7   <= x_s6;
		y_s7   <= y_s6;
		r2_s7  <= r2_s6;
		txy_s7 <= txy_s6;
		ax_s7  <= q_add(r2_s6, x2d_s6);
		ay_s7  <= q_add(r2_s6, y2d_s6);
	end

	assign out_valid  = vld_s[NORM_LAT];
	assign r2         = r2_s7;
	assign ctx.x      = x_s7;
	assign ctx.y      = y_s7;
	assign ctx.two_xy = txy_s7;
	assign ctx.ax     = ax_s7;
	assign ctx.ay     = ay_s7;
	assign ctx.tag    = tag_s[NORM_LAT];

endmodule

`default_nettype wire

// ===== rtl/core/dpp_poly.sv =====
// ----------------------------------------------------------------------------
// dpp_poly: radial numerator and denominator polynomials
// Evaluates 1+((c3*r2+c2)*r2+c1)*r2 for both polynomials by Horner steps.
// ----------------------------------------------------------------------------
`default_nettype none

module dpp_poly (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  dpp_pkg::q_t    r2,
	input  dpp_pkg::ctx_t  ctx_in,
	input  dpp_pkg::lens_t lens,
	output logic           out_valid,
	output dpp_pkg::q_t    num,
	output dpp_pkg::q_t    den,
	output dpp_pkg::ctx_t  ctx_out
);
	import dpp_pkg::*;

	logic [POLY_LAT:1] vld_s;
	ctx_t ctx_s [1:POLY_LAT];
	q_t   r2_s  [1:POLY_LAT-2];

	logic signed [63:0] pn_s1, pd_s1, pn_s3, pd_s3, pn_s5, pd_s5;
	q_t tn_s2, td_s2, tn_s4, td_s4, num_s6, den_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[POLY_LAT-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		ctx_s[1] <= ctx_in;
		r2_s[1]  <= r2;
		for (int k = 2; k <= POLY_LAT; k++) begin
			ctx_s[k] <= ctx_s[k-1];
		end
		for (int k = 2; k <= POLY_LAT - 2; k++) begin
			r2_s[k] <= r2_s[k-1];
		end
		pn_s1  <= lens.k3 * r2;
		pd_s1  <= lens.k6 * r2;
		tn_s2  <= q_add(mul_round(pn_s1), lens.k2);
		td_s2  <= q_add(mul_round(pd_s1), lens.k5);
		pn_s3  <= tn_s2 * r2_s[2];
		pd_s3  <= td_s2 * r2_s[2];
		tn_s4  <= q_add(mul_round(pn_s3), lens.k1);
		td_s4  <= q_add(mul_round(pd_s3), lens.k4);
		pn_s5  <= tn_s4 * r2_s[4];
		pd_s5  <= td_s4 * r2_s[4];
		num_s6 <= q_add(Q_ONE, mul_round(pn_s5));
		den_s6 <= q_add(Q_ONE, mul_round(pd_s5));
	end

	assign out_valid = vld_s[POLY_LAT];
	assign num       = num_s6;
	assign den       = den_s6;
	assign ctx_out   = ctx_s[POLY_LAT];

endmodule

`default_nettype wire

// ===== rtl/core/dpp_div.sv =====
// ----------------------------------------------------------------------------
// dpp_div: pipelined Q8.24 divider for the radial gain kr = num/den
// Restoring division, a fixed number of quotient bits per stage, rounded to
// nearest by the half-divisor dividend offset and saturated at the last stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dpp_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  dpp_pkg::q_t   num,
	input  dpp_pkg::q_t   den,
	input  dpp_pkg::ctx_t ctx_in,
	output logic          out_valid,
	output dpp_pkg::q_t   kr,
	output dpp_pkg::ctx_t ctx_out
);
	import dpp_pkg::*;

	logic [DIV_STEPS:0] vld_s;
	logic [31:0] rem_s [0:DIV_STEPS];
	logic [31:0] low_s [0:DIV_STEPS];
	logic [31:0] quo_s [0:DIV_STEPS];
	logic [31:0] md_s  [0:DIV_STEPS];
	dflag_t      flg_s [0:DIV_STEPS];
	ctx_t        ctx_s [0:DIV_STEPS];

	logic [31:0] mn, md;
	logic [55:0] nn;
	logic        out_valid_q;
	q_t          kr_q;
	ctx_t        ctx_q;

	assign mn = num[31] ? 32'(-num) : 32'(num);
	assign md = den[31] ? 32'(-den) : 32'(den);
	// dividend: |num| << 24 plus half the divisor for round to nearest
	assign nn = {mn, 24'b0} + {25'b0, md[31:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s       <= {vld_s[DIV_STEPS-1:0], in_valid};
			out_valid_q <= vld_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]      <= {8'b0, nn[55:32]};
		low_s[0]      <= nn[31:0];
		quo_s[0]      <= '0;
		md_s[0]       <= md;
		// quotient needs more than 32 bits: saturate
		flg_s[0].ovf  <= {8'b0, nn[55:32]} >= md;
		flg_s[0].mdz  <= (md == '0);
		flg_s[0].mnz  <= (mn == '0);
		flg_s[0].nneg <= num[31];
		flg_s[0].neg  <= num[31] ^ den[31];
		ctx_s[0]      <= ctx_in;
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		dstep_t st;
		assign st = div_step(rem_s[k-1], low_s[k-1][31 -: DIV_BITS], md_s[k-1]);
		always_ff @(posedge clk) begin
			rem_s[k] <= st.rem;
			low_s[k] <= low_s[k-1] << DIV_BITS;
			quo_s[k] <= {quo_s[k-1][31-DIV_BITS:0], st.q};
			md_s[k]  <= md_s[k-1];
			flg_s[k] <= flg_s[k-1];
			ctx_s[k] <= ctx_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		ctx_q <= ctx_s[DIV_STEPS];
		priority if (flg_s[DIV_STEPS].mdz) begin
			if (flg_s[DIV_STEPS].mnz) kr_q <= '0;
			else kr_q <= flg_s[DIV_STEPS].nneg ? Q_MIN : Q_MAX;
		end else if (flg_s[DIV_STEPS].ovf) begin
			kr_q <= flg_s[DIV_STEPS].neg ? Q_MIN : Q_MAX;
		end else begin
			kr_q <= apply_sign({16'b0, quo_s[DIV_STEPS]}, flg_s[DIV_STEPS].neg);
		end
	end

	assign out_valid = out_valid_q;
	assign kr        = kr_q;
	assign ctx_out   = ctx_q;

endmodule

`default_nettype wire

// ===== rtl/core/dpp_ray.sv =====
// ----------------------------------------------------------------------------
// dpp_ray: distorted ray
// rx = x*kr + p1*2xy + p2*(r2+2x2), ry = y*kr + p1*(r2+2y2) + p2*2xy.
// ----------------------------------------------------------------------------
`default_nettype none

module dpp_ray (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  dpp_pkg::q_t   kr,
	input  dpp_pkg::ctx_t ctx,
	input  dpp_pkg::q_t   p1,
	input  dpp_pkg::q_t   p2,
	output logic          out_valid,
	output dpp_pkg::q_t   rx,
	output dpp_pkg::q_t   ry,
	output dpp_pkg::tag_t tag_out
);
	import dpp_pkg::*;

	logic [RAY_LAT:1] vld_s;
	tag_t tag_s [1:RAY_LAT];

	logic signed [63:0] pxk_s1, ptx_s1, pax_s1, pyk_s1, pay_s1, pty_s1;
	q_t sx_s2, cx_s2, sy_s2, cy_s2, rx_s3, ry_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[RAY_LAT-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		tag_s[1] <= ctx.tag;
		for (int k = 2; k <= RAY_LAT; k++) begin
			tag_s[k] <= tag_s[k-1];
		end
		pxk_s1 <= ctx.x * kr;
		ptx_s1 <= p1 * ctx.two_xy;
		pax_s1 <= p2 * ctx.ax;
		pyk_s1 <= ctx.y * kr;
		pay_s1 <= p1 * ctx.ay;
		pty_s1 <= p2 * ctx.two_xy;
		sx_s2  <= q_add(mul_round(pxk_s1), mul_round(ptx_s1));
		cx_s2  <= mul_round(pax_s1);
		sy_s2  <= q_add(mul_round(pyk_s1), mul_round(pay_s1));
		cy_s2  <= mul_round(pty_s1);
		// drop the ray when coefficients are not loaded or the pixel is off image
		rx_s3  <= tag_s[2].en ? q_add(sx_s2, cx_s2) : '0;
		ry_s3  <= tag_s[2].en ? q_add(sy_s2, cy_s2) : '0;
	end

	assign out_valid = vld_s[RAY_LAT];
	assign rx        = rx_s3;
	assign ry        = ry_s3;
	assign tag_out   = tag_s[RAY_LAT];

endmodule

`default_nettype wire

// ===== rtl/core/dpp_scale.sv =====
// ----------------------------------------------------------------------------
// dpp_scale: depth scaling to metres
// x,y = round(ray*depth/256000), z = round(depth*65536/1000); the constant
// divide by 125 works on two 18-bit halves, each by a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module dpp_scale (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  dpp_pkg::q_t     rx,
	input  dpp_pkg::q_t     ry,
	input  dpp_pkg::tag_t   tag,
	output logic            done,
	output dpp_pkg::point_t point
);
	import dpp_pkg::*;

	logic [SCALE_LAT-1:1] vld_s;

	logic signed [47:0] prx_s1, pry_s1;
	logic [15:0]        depth_s1;
	logic               miss_s1;

	logic [47:0] magx, magy, sumx, sumy;
	logic [31:0] zsum;

	// lane 0 is x, lane 1 is y, lane 2 is z
	logic [SC_SPLIT-1:0] th_s2 [0:SC_LANES-1];
	logic [SC_SPLIT-1:0] tl_s2 [0:SC_LANES-1];
	logic [SC_SPLIT-1:0] th_s3 [0:SC_LANES-1];
	logic [SC_SPLIT-1:0] tl_s3 [0:SC_LANES-1];
	logic [43:0]         ph_s3 [0:SC_LANES-1];
	logic [SC_SPLIT-1:0] qm    [0:SC_LANES-1];
	logic [11:0]         qh_s4 [0:SC_LANES-1];
	logic [6:0]          rh_s4 [0:SC_LANES-1];
	logic [SC_SPLIT-1:0] tl_s4 [0:SC_LANES-1];
	logic [11:0]         qh_s5 [0:SC_LANES-1];
	logic [49:0]         pl_s5 [0:SC_LANES-1];

	logic [1:0] neg_s2, neg_s3, neg_s4, neg_s5;
	logic       miss_s2, miss_s3, miss_s4, miss_s5;

	logic   done_q;
	point_t point_q;

	assign magx = prx_s1[47] ? $unsigned(-prx_s1) : $unsigned(prx_s1);
	assign magy = pry_s1[47] ? $unsigned(-pry_s1) : $unsigned(pry_s1);
	assign sumx = magx + RND_SCALE;
	assign sumy = magy + RND_SCALE;
	assign zsum = {depth_s1, 16'b0} + Z_RND;

	// high quotient times 125, for the remainder of the high half
	always_comb begin
		for (int l = 0; l < SC_LANES; l++) begin
			qm[l] = SC_SPLIT'(ph_s3[l][43:32]) * SC_SPLIT'(DIV_C);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_s  <= {vld_s[SCALE_LAT-2:1], in_valid};
			done_q <= vld_s[SCALE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		prx_s1   <= rx * $signed({1'b0, tag.depth});
		pry_s1   <= ry * $signed({1'b0, tag.depth});
		depth_s1 <= tag.depth;
		miss_s1  <= (tag.depth == '0);
		// s2: drop the power-of-two part and split into high and low halves
		th_s2[0] <= sumx[SCALE_SHIFT+2*SC_SPLIT-1 -: SC_SPLIT];
		tl_s2[0] <= sumx[SCALE_SHIFT+SC_SPLIT-1 -: SC_SPLIT];
		th_s2[1] <= sumy[SCALE_SHIFT+2*SC_SPLIT-1 -: SC_SPLIT];
		tl_s2[1] <= sumy[SCALE_SHIFT+SC_SPLIT-1 -: SC_SPLIT];
		th_s2[2] <= SC_SPLIT'(zsum[31:Z_SHIFT+SC_SPLIT]);
		tl_s2[2] <= zsum[Z_SHIFT+SC_SPLIT-1 -: SC_SPLIT];
		neg_s2   <= {pry_s1[47], prx_s1[47]};
		miss_s2  <= miss_s1;
		for (int l = 0; l < SC_LANES; l++) begin
			// s3: high half times the reciprocal
			th_s3[l] <= th_s2[l];
			tl_s3[l] <= tl_s2[l];
			ph_s3[l] <= 44'(th_s2[l]) * 44'(RCP_125);
			// s4: high quotient and remainder
			qh_s4[l] <= ph_s3[l][43:32];
			rh_s4[l] <= 7'(th_s3[l] - qm[l]);
			tl_s4[l] <= tl_s3[l];
			// s5: remainder joined with the low half, times the reciprocal
			qh_s5[l] <= qh_s4[l];
			pl_s5[l] <= 50'({rh_s4[l], tl_s4[l]}) * 50'(RCP_125);
		end
		neg_s3  <= neg_s2;
		neg_s4  <= neg_s3;
		neg_s5  <= neg_s4;
		miss_s3 <= miss_s2;
		miss_s4 <= miss_s3;
		miss_s5 <= miss_s4;
		if (miss_s5) begin
			point_q.x_coord <= '0;
			point_q.y_coord <= '0;
			point_q.z_coord <= q_t'(Z_MISSING);
		end else begin
			point_q.x_coord <= apply_sign(48'({qh_s5[0], pl_s5[0][49:32]}), neg_s5[0]);
			point_q.y_coord <= apply_sign(48'({qh_s5[1], pl_s5[1][49:32]}), neg_s5[1]);
			point_q.z_coord <= q_t'(32'({qh_s5[2], pl_s5[2][49:32]}));
		end
	end

	assign done  = done_q;
	assign point = point_q;

endmodule

`default_nettype wire

// ===== rtl/core/depth_pixel_to_point_distorted_top.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_to_point_distorted_top: depth pixel to 3D point
// Back-projects a depth pixel through an 8-term rational radial plus
// tangential lens model and scales the ray by depth to a Q16.16 point.
//
//   channel  signals                         beat taken when
//   input    start, busy, pixel              start && !busy
//   result   done, point                     done (one cycle, no stall)
//   config   cfg_we, cfg_index, cfg_data     cfg_we
//
// One pixel is taken every clock; busy stays low.
// From start to done a pixel passes normalize, polynomial, the kr divider
// (16 two-bit restoring steps), ray and depth scaling, in that order.
// Reset clears the configuration and all pipeline valid bits; no clearing pass.
// The result side cannot stall, so the pipeline advances every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_pixel_to_point_distorted_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  dpp_pkg::pixel_t                   pixel,
	output logic                              done,
	output dpp_pkg::point_t                   point,
	input  logic                              cfg_we,
	input  logic [dpp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [63:0]                       cfg_data
);
	import dpp_pkg::*;

	logic [63:0] k12_q, k34_q, k56_q, tan_q, inv_q, pp_q;
	logic        cvalid_q;
	lens_t       lens;

	logic   nrm_valid, pol_valid, div_valid, ray_valid;
	q_t     r2, num, den, kr, rx, ry;
	ctx_t   ctx_n, ctx_p, ctx_d;
	tag_t   tag_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k12_q    <= '0;
			k34_q    <= '0;
			k56_q    <= '0;
			tan_q    <= '0;
			inv_q    <= '0;
			pp_q     <= '0;
			cvalid_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RADIAL_K12: k12_q    <= cfg_data;
				REG_RADIAL_K34: k34_q    <= cfg_data;
				REG_RADIAL_K56: k56_q    <= cfg_data;
				REG_TANGENTIAL: tan_q    <= cfg_data;
				REG_INV_FOCAL:  inv_q    <= cfg_data;
				REG_PRINCIPAL:  pp_q     <= cfg_data;
				REG_COEF_VALID: cvalid_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign lens.k1 = q_t'(k12_q[31:0]);
	assign lens.k2 = q_t'(k12_q[63:32]);
	assign lens.k3 = q_t'(k34_q[31:0]);
	assign lens.k4 = q_t'(k34_q[63:32]);
	assign lens.k5 = q_t'(k56_q[31:0]);
	assign lens.k6 = q_t'(k56_q[63:32]);

	assign busy = 1'b0;

	dpp_norm u_norm (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start && !busy),
		.pix        (pixel),
		.inv_focal  (inv_q),
		.principal  (pp_q),
		.coef_valid (cvalid_q),
		.out_valid  (nrm_valid),
		.r2         (r2),
		.ctx        (ctx_n)
	);

	dpp_poly u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (nrm_valid),
		.r2        (r2),
		.ctx_in    (ctx_n),
		.lens      (lens),
		.out_valid (pol_valid),
		.num       (num),
		.den       (den),
		.ctx_out   (ctx_p)
	);

	dpp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pol_valid),
		.num       (num),
		.den       (den),
		.ctx_in    (ctx_p),
		.out_valid (div_valid),
		.kr        (kr),
		.ctx_out   (ctx_d)
	);

	dpp_ray u_ray (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.kr        (kr),
		.ctx       (ctx_d),
		.p1        (q_t'(tan_q[31:0])),
		.p2        (q_t'(tan_q[63:32])),
		.out_valid (ray_valid),
		.rx        (rx),
		.ry        (ry),
		.tag_out   (tag_r)
	);

	dpp_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (ray_valid),
		.rx       (rx),
		.ry       (ry),
		.tag      (tag_r),
		.done     (done),
		.point    (point)
	);

	// every result beat traces back to an input beat a fixed latency earlier
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result beat without matching input beat");

	// the missing-depth marker always comes with a zero ray
	a_missing: assert property (@(posedge clk) disable iff (!arst_n)
		done && (point.z_coord == q_t'(Z_MISSING)) |->
			(point.x_coord == '0) && (point.y_coord == '0))
		else $error("missing depth with nonzero x/y");

	// z is negative only for the missing-depth marker
	a_z_sign: assert property (@(posedge clk) disable iff (!arst_n)
		done && point.z_coord[31] |-> (point.z_coord == q_t'(Z_MISSING)))
		else $error("negative z outside missing-depth marker");

endmodule

`default_nettype wire
